@@ src/rarh_pkg.sv @@
// Shared types and constants for the axis-aligned rectangle ray hit block.
// No dependencies.
package rarh_pkg;

    // Widths of the fixed-format fields
    localparam int TW  = 31;   // t, t_min, t_max
    localparam int UVW = 16;   // fraction bits of u and v
    localparam int UW  = 17;   // u and v field width
    localparam int MW  = 8;    // material tag

    typedef logic [1:0] t_axis;

    localparam t_axis AXIS_X    = 2'd0;
    localparam t_axis AXIS_Y    = 2'd1;
    localparam t_axis AXIS_Z    = 2'd2;
    localparam t_axis AXIS_NONE = 2'd3;   // selector with no plane

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_AXIS = 3'd0;
    localparam t_reg_idx REG_K    = 3'd1;
    localparam t_reg_idx REG_LO_A = 3'd2;
    localparam t_reg_idx REG_HI_A = 3'd3;
    localparam t_reg_idx REG_LO_B = 3'd4;
    localparam t_reg_idx REG_HI_B = 3'd5;
    localparam t_reg_idx REG_MAT  = 3'd6;

endpackage

@@ src/rarh_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per word.
// Used by rarh_div_chain; no package dependencies.
module rarh_div_cell #(
    parameter int RW = 33,
    parameter int QN = 31,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [RW-1:0] i_rem,
    input  logic [QN-1:0] i_low,
    input  logic [QN-1:0] i_quot,
    input  logic [RW-1:0] i_div,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [RW-1:0] o_rem,
    output logic [QN-1:0] o_low,
    output logic [QN-1:0] o_quot,
    output logic [RW-1:0] o_div,
    output logic [PW-1:0] o_pay
);

    logic [RW-1:0] w_trial;
    logic          w_ge;
    logic [RW-1:0] n_rem;
    logic          r_valid;
    logic [RW-1:0] r_rem;
    logic [QN-1:0] r_low;
    logic [QN-1:0] r_quot;
    logic [RW-1:0] r_div;
    logic [PW-1:0] r_pay;

    // shift the next dividend bit into the partial remainder
    assign w_trial = {i_rem[RW-2:0], i_low[QN-1]};
    assign w_ge    = (w_trial >= i_div);
    assign n_rem   = w_ge ? (w_trial - i_div) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_low  <= i_low << 1;
            r_quot <= {i_quot[QN-2:0], w_ge};
            r_div  <= i_div;
            r_pay  <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_low   = r_low;
    assign o_quot  = r_quot;
    assign o_div   = r_div;
    assign o_pay   = r_pay;

endmodule

@@ src/rarh_div_chain.sv @@
// Row of QN rarh_div_cell instances; one quotient bit per cell, one word per cycle while i_en is high.
// Depends on rarh_div_cell.
module rarh_div_chain #(
    parameter int RW = 33,
    parameter int QN = 31,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [RW-1:0] i_rem,
    input  logic [QN-1:0] i_low,
    input  logic [RW-1:0] i_div,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [QN-1:0] o_quot,
    output logic [PW-1:0] o_pay
);

    logic          w_valid [QN+1];
    logic [RW-1:0] w_rem   [QN+1];
    logic [QN-1:0] w_low   [QN+1];
    logic [QN-1:0] w_quot  [QN+1];
    logic [RW-1:0] w_div   [QN+1];
    logic [PW-1:0] w_pay   [QN+1];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = i_rem;
    assign w_low[0]   = i_low;
    assign w_quot[0]  = '0;
    assign w_div[0]   = i_div;
    assign w_pay[0]   = i_pay;

    for (genvar g = 0; g < QN; g++) begin : g_cell
        rarh_div_cell #(.RW(RW), .QN(QN), .PW(PW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[g]),
            .i_rem   (w_rem[g]),
            .i_low   (w_low[g]),
            .i_quot  (w_quot[g]),
            .i_div   (w_div[g]),
            .i_pay   (w_pay[g]),
            .o_valid (w_valid[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_low   (w_low[g+1]),
            .o_quot  (w_quot[g+1]),
            .o_div   (w_div[g+1]),
            .o_pay   (w_pay[g+1])
        );
    end

    assign o_valid = w_valid[QN];
    assign o_quot  = w_quot[QN];
    assign o_pay   = w_pay[QN];

endmodule

@@ src/axis_aligned_rect_ray_hit.sv @@
// Top level of the ray / axis-aligned rectangle hit engine.
// Depends on rarh_pkg and rarh_div_chain.
//
// One ray word in, one result word out, one ray per clock sustained while the
// output is not stalled. The pipe is one input stage, a 31-cell chain that
// forms t one quotient bit per cell, a multiply stage, a hit-point stage, a
// 17-cell chain that forms u and v side by side, and the output register. The
// whole pipe advances together whenever the output register is empty or being
// taken, so a stall on m_axis holds every stage and s_axis_tready drops with
// it. t is (k - origin) / dir on the plane axis, truncated toward zero; t below
// 0.001, outside [t_min, t_max], a zero direction on the plane axis or
// plane_axis 3 all give a miss, and a miss word is all zeros. Configuration
// goes through the APB port, one register per 32-bit word (64-bit words when
// COORD_WIDTH is above 32); write it only while no ray is in flight.
module axis_aligned_rect_ray_hit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // APB configuration
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [((COORD_WIDTH > 32) ? 3 : 2)+2:0] paddr,
    input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                                    pready,
    // ray words: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((6*COORD_WIDTH+2*rarh_pkg::TW+7)/8)*8-1:0] s_axis_tdata,
    // result words: hit, hit_t, hit_x, hit_y, hit_z, tex_u, tex_v, front_face,
    // hit_material
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((3*COORD_WIDTH+2*rarh_pkg::TW/31*0+rarh_pkg::TW+2*rarh_pkg::UW+2+rarh_pkg::MW+7)/8)*8-1:0] m_axis_tdata
);
    import rarh_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int FB      = FRAC_BITS;
    localparam int DW      = (CW > 32) ? 64 : 32;
    localparam int ALSB    = (CW > 32) ? 3 : 2;
    localparam int IN_W    = ((6*CW + 2*TW + 7) / 8) * 8;
    localparam int OUT_W   = ((3*CW + TW + 2*UW + 2 + MW + 7) / 8) * 8;
    localparam int NW      = CW + 1 + FB;        // |k - o| scaled by 2^FB
    localparam int RW      = CW + 1;             // remainder and divisor
    localparam int PRW     = CW + TW + 1;        // dir * t
    localparam int HW      = CW + TW + 2 - FB;   // full-precision hit coordinate
    localparam int PWT     = 4*CW + 2*TW + 2;    // payload through the t chain
    localparam int PWU     = 3*CW + TW + 3;      // payload through the u chain
    localparam logic [63:0] EPS64 = ((64'd1 << FB) + 64'd500) / 64'd1000;
    localparam logic [TW-1:0] T_EPS = EPS64[TW-1:0];

    // ---------------------------------------------------------------- config
    t_axis                   r_axis;
    logic signed [CW-1:0]    r_k, r_lo_a, r_hi_a, r_lo_b, r_hi_b;
    logic [MW-1:0]           r_mat;
    t_reg_idx                w_idx;
    logic                    w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ALSB +: 3];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= AXIS_Z;
            r_k    <= '0;
            r_lo_a <= '0;
            r_hi_a <= CW'(1) << FB;
            r_lo_b <= '0;
            r_hi_b <= CW'(1) << FB;
            r_mat  <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_AXIS: r_axis <= pwdata[1:0];
                REG_K:    r_k    <= pwdata[CW-1:0];
                REG_LO_A: r_lo_a <= pwdata[CW-1:0];
                REG_HI_A: r_hi_a <= pwdata[CW-1:0];
                REG_LO_B: r_lo_b <= pwdata[CW-1:0];
                REG_HI_B: r_hi_b <= pwdata[CW-1:0];
                REG_MAT:  r_mat  <= pwdata[MW-1:0];
                default: ;   // unmapped: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_AXIS: prdata = DW'(r_axis);
            REG_K:    prdata = DW'(r_k);
            REG_LO_A: prdata = DW'(r_lo_a);
            REG_HI_A: prdata = DW'(r_hi_a);
            REG_LO_B: prdata = DW'(r_lo_b);
            REG_HI_B: prdata = DW'(r_hi_b);
            REG_MAT:  prdata = DW'(r_mat);
            default:  prdata = '0;
        endcase
    end

    // -------------------------------------------------------- pipe control
    // Every stage moves when the output register is free or being drained.
    logic r_out_valid;
    logic w_en;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    // ------------------------------------------------ stage 1: plane select
    logic signed [CW-1:0] w_ox, w_oy, w_oz, w_dx, w_dy, w_dz;
    logic [TW-1:0]        w_tmin, w_tmax;
    logic signed [CW-1:0] w_op, w_dp, w_oa, w_ob, w_da, w_db;
    logic signed [CW:0]   w_diff;
    logic [CW:0]          w_diff_mag;
    logic [CW-1:0]        w_dmag;

    assign w_ox   = s_axis_tdata[0*CW +: CW];
    assign w_oy   = s_axis_tdata[1*CW +: CW];
    assign w_oz   = s_axis_tdata[2*CW +: CW];
    assign w_dx   = s_axis_tdata[3*CW +: CW];
    assign w_dy   = s_axis_tdata[4*CW +: CW];
    assign w_dz   = s_axis_tdata[5*CW +: CW];
    assign w_tmin = s_axis_tdata[6*CW +: TW];
    assign w_tmax = s_axis_tdata[6*CW+TW +: TW];

    // a/b are the in-plane axes: (y,z) for x, (x,z) for y, (x,y) for z
    always_comb begin
        unique case (r_axis)
            AXIS_X: begin
                w_op = w_ox; w_dp = w_dx;
                w_oa = w_oy; w_da = w_dy; w_ob = w_oz; w_db = w_dz;
            end
            AXIS_Y: begin
                w_op = w_oy; w_dp = w_dy;
                w_oa = w_ox; w_da = w_dx; w_ob = w_oz; w_db = w_dz;
            end
            default: begin
                w_op = w_oz; w_dp = w_dz;
                w_oa = w_ox; w_da = w_dx; w_ob = w_oy; w_db = w_dy;
            end
        endcase
    end

    assign w_diff     = r_k - w_op;
    assign w_diff_mag = w_diff[CW] ? $unsigned(-w_diff) : $unsigned(w_diff);
    assign w_dmag     = w_dp[CW-1] ? $unsigned(-w_dp) : $unsigned(w_dp);

    logic                 r1_valid;
    logic [NW-1:0]        r1_num;
    logic [CW-1:0]        r1_dmag;
    logic                 r1_rej;
    logic                 r1_front;
    logic signed [CW-1:0] r1_oa, r1_ob, r1_da, r1_db;
    logic [TW-1:0]        r1_tmin, r1_tmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_num   <= {w_diff_mag, {FB{1'b0}}};
            r1_dmag  <= w_dmag;
            // zero direction, no plane, or a negative quotient: miss
            r1_rej   <= (w_dp == '0) || (r_axis == AXIS_NONE) ||
                        (w_diff[CW] != w_dp[CW-1]);
            r1_front <= w_dp[CW-1];
            r1_oa    <= w_oa;
            r1_ob    <= w_ob;
            r1_da    <= w_da;
            r1_db    <= w_db;
            r1_tmin  <= w_tmin;
            r1_tmax  <= w_tmax;
        end
    end

    // ------------------------------------------------------ t divider chain
    logic          w_ovf;
    logic [PWT-1:0] w_pay_t_in, w_pay_t_out;
    logic          w_t_valid;
    logic [TW-1:0] w_t;

    // quotient would not fit TW bits: t is beyond any t_max
    assign w_ovf      = (r1_num >> TW) >= NW'(r1_dmag);
    assign w_pay_t_in = {r1_rej || w_ovf, r1_front, r1_tmax, r1_tmin,
                         r1_db, r1_da, r1_ob, r1_oa};

    rarh_div_chain #(.RW(RW), .QN(TW), .PW(PWT)) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_valid),
        .i_rem   (RW'(r1_num >> TW)),
        .i_low   (r1_num[TW-1:0]),
        .i_div   ({1'b0, r1_dmag}),
        .i_pay   (w_pay_t_in),
        .o_valid (w_t_valid),
        .o_quot  (w_t),
        .o_pay   (w_pay_t_out)
    );

    // -------------------------------------------- stage M: window and multiply
    logic                 w2_rej, w2_front;
    logic [TW-1:0]        w2_tmin, w2_tmax;
    logic signed [CW-1:0] w2_oa, w2_ob, w2_da, w2_db;

    assign {w2_rej, w2_front, w2_tmax, w2_tmin, w2_db, w2_da, w2_ob, w2_oa} = w_pay_t_out;

    logic                  rm_valid, rm_rej, rm_front;
    logic [TW-1:0]         rm_t;
    logic signed [CW-1:0]  rm_oa, rm_ob;
    logic signed [PRW-1:0] rm_pa, rm_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_valid <= 1'b0;
        end else if (w_en) begin
            rm_valid <= w_t_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rm_rej   <= w2_rej || (w_t < w2_tmin) || (w_t > w2_tmax) || (w_t < T_EPS);
            rm_front <= w2_front;
            rm_t     <= w_t;
            rm_oa    <= w2_oa;
            rm_ob    <= w2_ob;
            rm_pa    <= w2_da * $signed({1'b0, w_t});
            rm_pb    <= w2_db * $signed({1'b0, w_t});
        end
    end

    // ------------------------------------------------- stage H: hit point
    logic                 rh_valid, rh_rej, rh_front;
    logic [TW-1:0]        rh_t;
    logic signed [HW-1:0] rh_ha, rh_hb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rh_valid <= 1'b0;
        end else if (w_en) begin
            rh_valid <= rm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rh_rej   <= rm_rej;
            rh_front <= rm_front;
            rh_t     <= rm_t;
            // arithmetic shift is the floor of dir*t / 2^FB
            rh_ha    <= HW'(rm_oa) + HW'(rm_pa >>> FB);
            rh_hb    <= HW'(rm_ob) + HW'(rm_pb >>> FB);
        end
    end

    // ----------------------------------------- bounds, saturation, uv chains
    function automatic logic signed [CW-1:0] f_sat(input logic signed [HW-1:0] h);
        logic [HW-CW:0] top;
        top = h[HW-1:CW-1];
        if ((&top) || !(|top)) begin
            f_sat = h[CW-1:0];
        end else if (h[HW-1]) begin
            f_sat = {1'b1, {(CW-1){1'b0}}};
        end else begin
            f_sat = {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    logic                 w_hit;
    logic signed [CW-1:0] w_sa, w_sb, w_hx, w_hy, w_hz;
    logic [HW-1:0]        w_ua_full, w_vb_full;
    logic [RW-1:0]        w_ua, w_vb;
    logic signed [CW:0]   w_den_a, w_den_b;
    logic [PWU-1:0]       w_pay_u_in, w_pay_u_out;
    logic                 w_pay_v_out;

    assign w_hit = !rh_rej &&
                   (rh_ha >= HW'(r_lo_a)) && (rh_ha <= HW'(r_hi_a)) &&
                   (rh_hb >= HW'(r_lo_b)) && (rh_hb <= HW'(r_hi_b));

    assign w_sa = f_sat(rh_ha);
    assign w_sb = f_sat(rh_hb);

    always_comb begin
        unique case (r_axis)
            AXIS_X:  begin w_hx = r_k;  w_hy = w_sa; w_hz = w_sb; end
            AXIS_Y:  begin w_hx = w_sa; w_hy = r_k;  w_hz = w_sb; end
            default: begin w_hx = w_sa; w_hy = w_sb; w_hz = r_k;  end
        endcase
    end

    // on a hit, 0 <= h - lo <= hi - lo, so the quotient fits UW bits
    assign w_ua_full = rh_ha - HW'(r_lo_a);
    assign w_vb_full = rh_hb - HW'(r_lo_b);
    assign w_ua      = w_ua_full[RW-1:0];
    assign w_vb      = w_vb_full[RW-1:0];
    assign w_den_a   = r_hi_a - r_lo_a;
    assign w_den_b   = r_hi_b - r_lo_b;

    assign w_pay_u_in = {w_den_a == '0, rh_front, w_hz, w_hy, w_hx, rh_t, w_hit};

    logic          w_u_valid, w_v_valid;
    logic [UW-1:0] w_uq, w_vq;

    rarh_div_chain #(.RW(RW), .QN(UW), .PW(PWU)) u_udiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (rh_valid),
        .i_rem   (w_ua >> 1),
        .i_low   ({w_ua[0], {UVW{1'b0}}}),
        .i_div   ($unsigned(w_den_a)),
        .i_pay   (w_pay_u_in),
        .o_valid (w_u_valid),
        .o_quot  (w_uq),
        .o_pay   (w_pay_u_out)
    );

    rarh_div_chain #(.RW(RW), .QN(UW), .PW(1)) u_vdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (rh_valid),
        .i_rem   (w_vb >> 1),
        .i_low   ({w_vb[0], {UVW{1'b0}}}),
        .i_div   ($unsigned(w_den_b)),
        .i_pay   (w_den_b == '0),
        .o_valid (w_v_valid),
        .o_quot  (w_vq),
        .o_pay   (w_pay_v_out)
    );

    // ------------------------------------------------------ output register
    logic                 w3_hit, w3_front, w3_dzu;
    logic [TW-1:0]        w3_t;
    logic signed [CW-1:0] w3_x, w3_y, w3_z;

    assign {w3_dzu, w3_front, w3_z, w3_y, w3_x, w3_t, w3_hit} = w_pay_u_out;

    logic                 r_hit, r_front;
    logic [TW-1:0]        r_t;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic [UW-1:0]        r_u, r_v;
    logic [MW-1:0]        r_omat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_u_valid && w_v_valid;
        end
    end

    // a miss word is all zeros; a flat rectangle side gives 0 on that axis
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit   <= w3_hit;
            r_t     <= w3_hit ? w3_t : '0;
            r_x     <= w3_hit ? w3_x : '0;
            r_y     <= w3_hit ? w3_y : '0;
            r_z     <= w3_hit ? w3_z : '0;
            r_u     <= (w3_hit && !w3_dzu) ? w_uq : '0;
            r_v     <= (w3_hit && !w_pay_v_out) ? w_vq : '0;
            r_front <= w3_hit && w3_front;
            r_omat  <= w3_hit ? r_mat : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_omat, r_front, r_v, r_u, r_z, r_y, r_x, r_t, r_hit});

    // ------------------------------------------------------------ checks
    a_uv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_hit |-> (r_u <= UW'(1 << UVW)) && (r_v <= UW'(1 << UVW)))
        else $error("texture coordinate above 1.0 on a hit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_hit |-> (r_t == '0) && (r_u == '0) && !r_front && (r_omat == '0))
        else $error("miss word not cleared");

    a_t_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_hit |-> (r_t >= T_EPS))
        else $error("hit reported with t below the minimum distance");

    a_chains_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_u_valid == w_v_valid)
        else $error("u and v chains out of step");

endmodule
